>>> rtl/core/amplitude_pot_spi_writer_macros.svh
// Assertion macros for the amplitude potentiometer serial writer.
// Used by the top level only; no other dependencies.
`ifndef AMPLITUDE_POT_SPI_WRITER_MACROS_SVH
`define AMPLITUDE_POT_SPI_WRITER_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define APSW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define APSW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/apsw_pkg.sv
// Shared types and constants for the amplitude potentiometer serial writer.
// No dependencies.
package apsw_pkg;

    localparam int CODE_W   = 8;
    localparam int MV_W     = 16;
    localparam int HALF_W   = 8;
    localparam int FRAME_W  = 16;
    localparam int BITPOS_W = 4;
    localparam int PROD_W   = MV_W + CODE_W;
    localparam int DIVCNT_W = 3;

    localparam logic [CODE_W-1:0]   WRITE_COMMAND = 8'h11;
    localparam logic [CODE_W-1:0]   CODE_FULL     = 8'd255;
    localparam logic [BITPOS_W-1:0] FIRST_BIT     = 4'd15;
    localparam logic [DIVCNT_W-1:0] DIV_LAST      = 3'd7;

    localparam logic [MV_W-1:0]   MIN_RESET  = 16'd0;
    localparam logic [MV_W-1:0]   MAX_RESET  = 16'd3300;
    localparam logic [HALF_W-1:0] HALF_RESET = 8'd12;

    typedef enum logic [1:0] {
        REG_MIN_MV   = 2'd0,
        REG_MAX_MV   = 2'd1,
        REG_HALF_BIT = 2'd2
    } cfg_index_t;

    // Controller to datapath
    typedef struct packed {
        logic tick;       // advance serial timing by one tick
        logic take;       // request accepted: latch rejected flag
        logic reject;     // value of rejected flag on take
        logic load;       // clamp and latch operands
        logic mul;        // register scaled numerator
        logic div_init;   // seed divider from product
        logic div_step;   // one quotient bit
        logic commit;     // store code, start frame
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic active;     // frame in progress
    } dp_status_t;

endpackage

>>> rtl/core/apsw_dp.sv
// Datapath: config registers, scaler (multiply + restoring divide), serial timing.
// Depends on apsw_pkg.
module apsw_dp
    import apsw_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic [MV_W-1:0]     amplitude_mv,
    input  dp_cmd_t             cmd,
    output dp_status_t          status,
    output logic                chip_select_n,
    output logic                serial_clock,
    output logic                serial_data,
    output logic                busy_res,
    output logic [CODE_W-1:0]   pot_code,
    output logic                rejected
);

    logic [MV_W-1:0]     min_reg, max_reg;
    logic [HALF_W-1:0]   half_reg;
    logic [MV_W-1:0]     diff_reg, span_reg;
    logic                span_zero_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [MV_W-1:0]     rem_reg;
    logic [CODE_W-1:0]   quo_reg;

    logic [FRAME_W-1:0]  frame_reg;
    logic [BITPOS_W-1:0] bitpos_reg;
    logic                clk_high_reg;
    logic [HALF_W-1:0]   wait_reg;
    logic                active_reg;
    logic [CODE_W-1:0]   code_reg;
    logic                data_reg;
    logic                rejected_reg;

    logic [FRAME_W-1:0]  frame_next;
    logic [BITPOS_W-1:0] bitpos_next;
    logic                clk_high_next;
    logic [HALF_W-1:0]   wait_next;
    logic                active_next;
    logic [CODE_W-1:0]   code_next;
    logic                data_next;

    logic [HALF_W-1:0]   half_load;
    logic [MV_W-1:0]     clamp_lo, clamp_v;
    logic [MV_W:0]       trial;
    logic                trial_ge;
    logic [MV_W:0]       trial_sub;
    logic [HALF_W-1:0]   wait_dec;
    logic [BITPOS_W-1:0] bitpos_dec;

    assign half_load = (half_reg == '0) ? HALF_W'(1) : half_reg;

    // clamp to [min, max]; result unused when max <= min
    assign clamp_lo = (amplitude_mv < min_reg) ? min_reg : amplitude_mv;
    assign clamp_v  = (clamp_lo > max_reg) ? max_reg : clamp_lo;

    // restoring divide step, quotient bits shift in as numerator bits shift out
    assign trial     = {rem_reg, quo_reg[CODE_W-1]};
    assign trial_ge  = trial >= {1'b0, span_reg};
    assign trial_sub = trial - {1'b0, span_reg};

    assign wait_dec   = (wait_reg != '0) ? wait_reg - HALF_W'(1) : wait_reg;
    assign bitpos_dec = bitpos_reg - BITPOS_W'(1);

    always_comb
    begin
        frame_next    = frame_reg;
        bitpos_next   = bitpos_reg;
        clk_high_next = clk_high_reg;
        wait_next     = wait_reg;
        active_next   = active_reg;
        code_next     = code_reg;
        data_next     = data_reg;
        if (cmd.commit)
        begin
            code_next     = span_zero_reg ? '0 : quo_reg;
            frame_next    = {WRITE_COMMAND, code_next};
            bitpos_next   = FIRST_BIT;
            data_next     = frame_next[FIRST_BIT];
            clk_high_next = 1'b0;
            wait_next     = half_load;
            active_next   = 1'b1;
        end
        else if (cmd.tick && active_reg)
        begin
            wait_next = wait_dec;
            if (wait_dec == '0)
            begin
                if (!clk_high_reg)
                begin
                    clk_high_next = 1'b1;
                    wait_next     = half_load;
                end
                else if (bitpos_reg == '0)
                begin
                    active_next = 1'b0;
                end
                else
                begin
                    bitpos_next   = bitpos_dec;
                    clk_high_next = 1'b0;
                    data_next     = frame_reg[bitpos_dec];
                    wait_next     = half_load;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg      <= MIN_RESET;
            max_reg      <= MAX_RESET;
            half_reg     <= HALF_RESET;
            frame_reg    <= '0;
            bitpos_reg   <= FIRST_BIT;
            clk_high_reg <= 1'b0;
            wait_reg     <= '0;
            active_reg   <= 1'b0;
            code_reg     <= '0;
            data_reg     <= 1'b0;
            rejected_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MIN_MV:   min_reg  <= cfg_data;
                    REG_MAX_MV:   max_reg  <= cfg_data;
                    REG_HALF_BIT: half_reg <= cfg_data[HALF_W-1:0];
                    default:      ;
                endcase
            end
            if (cmd.take)
                rejected_reg <= cmd.reject;
            frame_reg    <= frame_next;
            bitpos_reg   <= bitpos_next;
            clk_high_reg <= clk_high_next;
            wait_reg     <= wait_next;
            active_reg   <= active_next;
            code_reg     <= code_next;
            data_reg     <= data_next;
        end
    end

    // scaler pipeline, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            diff_reg      <= clamp_v - min_reg;
            span_reg      <= max_reg - min_reg;
            span_zero_reg <= (max_reg <= min_reg);
        end
        if (cmd.mul)
            prod_reg <= PROD_W'(diff_reg) * PROD_W'(CODE_FULL);
        if (cmd.div_init)
        begin
            rem_reg <= prod_reg[PROD_W-1:CODE_W];
            quo_reg <= prod_reg[CODE_W-1:0];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? trial_sub[MV_W-1:0] : trial[MV_W-1:0];
            quo_reg <= {quo_reg[CODE_W-2:0], trial_ge};
        end
    end

    assign status.active = active_reg;
    assign chip_select_n = !active_reg;
    assign serial_clock  = clk_high_reg;
    assign serial_data   = data_reg;
    assign busy_res      = active_reg;
    assign pot_code      = code_reg;
    assign rejected      = rejected_reg;

endmodule

>>> rtl/core/apsw_ctrl.sv
// Controller: request handshake, scaler sequencing, result valid.
// Depends on apsw_pkg.
module apsw_ctrl
    import apsw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       action,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_PREP,
        ST_DIV,
        ST_COMMIT
    } state_t;

    state_t              state_reg, state_next;
    logic [DIVCNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                out_valid_reg, out_valid_next;
    logic                accept;

    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        div_cnt_next   = div_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (action && !status.active)
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        cmd.tick       = !action;
                        out_valid_next = 1'b1;
                    end
                    cmd.take   = 1'b1;
                    cmd.reject = action && status.active;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                cmd.div_init = 1'b1;
                div_cnt_next = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + DIVCNT_W'(1);
                if (div_cnt_reg == DIV_LAST)
                    state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                cmd.commit     = 1'b1;
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> rtl/core/amplitude_pot_spi_writer.sv
// Top level of the amplitude potentiometer serial writer.
// Depends on apsw_pkg, apsw_ctrl, apsw_dp and amplitude_pot_spi_writer_macros.svh.
//
// Each request on the input channel is either a time tick (action 0) or a new
// amplitude request (action 1), and each produces exactly one result giving the
// pin levels (chip_select_n, serial_clock, serial_data), busy, the current pot
// code and a rejected flag. A tick, or an amplitude request made while a frame
// is still going out (rejected), has its result valid in the next cycle: with
// the result taken at once, ticks are accepted every clock. An accepted
// amplitude request that starts a frame goes through clamp and operand latch,
// one 16x8 multiply by 255, divider seed, the restoring divider (one quotient
// bit per cycle), then commit of the code and the start of the frame. The
// result register holds one finished result, and the next request is taken in
// the same cycle the held result is taken. The frame is 0x11 followed by the
// code, MSB first; each bit spends half_bit_ticks ticks with the clock low and
// as many with it high (a setting of 0 counts as 1). After the frame the clock
// stays high and data keeps the last bit. Configuration writes are always
// accepted (cfg_ready is tied high); index 0 is min_millivolts, 1 is
// max_millivolts, 2 is half_bit_ticks, 3 is ignored. Write them only while idle.
`include "amplitude_pot_spi_writer_macros.svh"

module amplitude_pot_spi_writer
    import apsw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // request channel
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              action,
    input  logic [MV_W-1:0]   amplitude_mv,
    // result channel
    output logic              out_valid,
    input  logic              out_ready,
    output logic              chip_select_n,
    output logic              serial_clock,
    output logic              serial_data,
    output logic              busy_res,
    output logic [CODE_W-1:0] pot_code,
    output logic              rejected,
    // configuration write channel
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    // sequencing: handshakes and scaler steps
    apsw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // config, scaler and serial pin state; pin state doubles as the result register
    apsw_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .amplitude_mv  (amplitude_mv),
        .cmd           (cmd),
        .status        (status),
        .chip_select_n (chip_select_n),
        .serial_clock  (serial_clock),
        .serial_data   (serial_data),
        .busy_res      (busy_res),
        .pot_code      (pot_code),
        .rejected      (rejected)
    );

    // request while busy must come back at once, flagged rejected
    `APSW_ASSERT_NEXT(a_reject_now, in_valid && in_ready && action && busy_res, out_valid && rejected && busy_res, "busy request not rejected")

    // an accepted request while idle runs the scaler, so input stalls next cycle
    `APSW_ASSERT_NEXT(a_scale_stall, in_valid && in_ready && action && !busy_res, !in_ready && !out_valid, "scaler did not stall input")

    // serial clock moves only as part of a frame
    `APSW_ASSERT_NEXT(a_clk_idle, !busy_res, $stable(serial_clock) || busy_res, "serial clock moved while idle")

endmodule
